// File: hw/rtl/lpi_pkg.sv
// ----------------------------------------------------------------------------
// lpi_pkg
// shared constants, register codes and status types of the line/plane
// intersection block
// ----------------------------------------------------------------------------
package lpi_pkg;

   localparam int DATA_WIDTH     = 64;
   localparam int ADDR_WIDTH     = 6;
   localparam int REG_WIDTH      = 48;
   localparam int TOL_WIDTH      = 48;
   localparam int DEGEN_MAG_BITS = 24;

   localparam logic [2:0] REG_POINT_ONE    = 3'd0;
   localparam logic [2:0] REG_POINT_TWO    = 3'd1;
   localparam logic [2:0] REG_POINT_THREE  = 3'd2;
   localparam logic [2:0] REG_PLANE_TOL    = 3'd3;
   localparam logic [2:0] REG_PARALLEL_TOL = 3'd4;

   localparam logic [2:0] SETTLE_CYCLES = 3'd5;

   typedef struct packed {
      logic is_parallel;
      logic start_on_plane;
      logic plane_degenerate;
   } flags_type;

endpackage

// File: hw/rtl/lpi_if.sv
// ----------------------------------------------------------------------------
// lpi_if
// valid/ready channels for line transactions and intersection results
// ----------------------------------------------------------------------------
interface lpi_req_if #(parameter int W = 16);
   logic                valid;
   logic                ready;
   logic signed [W-1:0] start_x;
   logic signed [W-1:0] start_y;
   logic signed [W-1:0] start_z;
   logic signed [W-1:0] end_x;
   logic signed [W-1:0] end_y;
   logic signed [W-1:0] end_z;

   modport source (output valid, start_x, start_y, start_z, end_x, end_y, end_z,
                   input ready);
   modport sink (input valid, start_x, start_y, start_z, end_x, end_y, end_z,
                 output ready);
endinterface

interface lpi_rsp_if #(parameter int W = 16);
   logic                valid;
   logic                ready;
   logic signed [W-1:0] hit_x;
   logic signed [W-1:0] hit_y;
   logic signed [W-1:0] hit_z;
   logic                is_parallel;
   logic                start_on_plane;
   logic                plane_degenerate;
   logic                hit_saturated;

   modport source (output valid, hit_x, hit_y, hit_z, is_parallel, start_on_plane,
                   plane_degenerate, hit_saturated, input ready);
   modport sink (input valid, hit_x, hit_y, hit_z, is_parallel, start_on_plane,
                 plane_degenerate, hit_saturated, output ready);
endinterface

// File: hw/rtl/lpi_plane.sv
// ----------------------------------------------------------------------------
// lpi_plane
// register file and plane coefficient derivation pipeline
// ----------------------------------------------------------------------------
module lpi_plane import lpi_pkg::*; #(
   parameter int W = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    psel,
   input  logic                    penable,
   input  logic                    pwrite,
   input  logic [ADDR_WIDTH-1:0]   paddr,
   input  logic [DATA_WIDTH-1:0]   pwdata,
   output logic [DATA_WIDTH-1:0]   prdata,
   output logic                    pready,
   output logic signed [2*W+2:0]   normal_a,
   output logic signed [2*W+2:0]   normal_b,
   output logic signed [2*W+2:0]   normal_c,
   output logic signed [3*W+5:0]   offset_d,
   output logic                    plane_degenerate,
   output logic [TOL_WIDTH-1:0]    plane_tol,
   output logic [TOL_WIDTH-1:0]    parallel_tol,
   output logic                    settled
);

   localparam int PW   = 3 * W;
   localparam int PB   = (PW < REG_WIDTH) ? PW : REG_WIDTH;
   localparam int NW   = 2 * W + 3;
   localparam int SW   = 3 * W + 6;
   localparam int PRW  = 2 * W + 2;
   localparam int XW   = 3 * W + 3;
   localparam int MAGW = (NW > DEGEN_MAG_BITS) ? NW : DEGEN_MAG_BITS + 1;
   localparam int SQW  = 2 * DEGEN_MAG_BITS;
   localparam int SUMW = SQW + 2;

   logic [2:0][PB-1:0]   point_ff;
   logic [TOL_WIDTH-1:0] plane_tol_ff;
   logic [TOL_WIDTH-1:0] parallel_tol_ff;
   logic [2:0]           settle_ff;

   logic       wr;
   logic [2:0] idx;

   assign wr     = psel & penable & pwrite;
   assign idx    = paddr[ADDR_WIDTH-1:3];
   assign pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         point_ff[0]     <= PB'(64'd0);
         point_ff[1]     <= PB'(64'd256);
         point_ff[2]     <= PB'(64'd16777216);
         plane_tol_ff    <= TOL_WIDTH'(1);
         parallel_tol_ff <= TOL_WIDTH'(1);
         settle_ff       <= SETTLE_CYCLES;
      end else begin
         if (wr) begin
            settle_ff <= SETTLE_CYCLES;
            case (idx)
               REG_POINT_ONE:    point_ff[0]     <= pwdata[PB-1:0];
               REG_POINT_TWO:    point_ff[1]     <= pwdata[PB-1:0];
               REG_POINT_THREE:  point_ff[2]     <= pwdata[PB-1:0];
               REG_PLANE_TOL:    plane_tol_ff    <= pwdata[TOL_WIDTH-1:0];
               REG_PARALLEL_TOL: parallel_tol_ff <= pwdata[TOL_WIDTH-1:0];
               default: ;
            endcase
         end else if (settle_ff != 3'd0) begin
            settle_ff <= settle_ff - 3'd1;
         end
      end
   end

   always_comb begin
      case (idx)
         REG_POINT_ONE:    prdata = DATA_WIDTH'(point_ff[0]);
         REG_POINT_TWO:    prdata = DATA_WIDTH'(point_ff[1]);
         REG_POINT_THREE:  prdata = DATA_WIDTH'(point_ff[2]);
         REG_PLANE_TOL:    prdata = DATA_WIDTH'(plane_tol_ff);
         REG_PARALLEL_TOL: prdata = DATA_WIDTH'(parallel_tol_ff);
         default:          prdata = '0;
      endcase
   end

   // derivation pipeline
   logic [PW-1:0]        ext [3];
   logic signed [W-1:0]  p1_c [3];
   logic signed [W-1:0]  p2_c [3];
   logic signed [W-1:0]  p3_c [3];
   logic signed [W:0]    u_in [3];
   logic signed [W:0]    v_in [3];
   logic signed [W:0]    u_ff [3];
   logic signed [W:0]    v_ff [3];
   logic signed [W-1:0]  x1_d1_ff [3];
   logic signed [W-1:0]  x1_d2_ff [3];
   logic signed [W-1:0]  x1_d3_ff [3];
   logic signed [PRW-1:0] m_ff [6];
   logic signed [NW-1:0] n_ff [3];
   logic signed [XW-1:0] px_ff [3];
   logic [NW-1:0]        nmag [3];
   logic [MAGW-1:0]      magx [3];
   logic                 big_ff [3];
   logic [SQW-1:0]       sq_ff [3];
   logic signed [SW-1:0] d_ff;
   logic                 degen_ff;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         ext[k] = PW'(point_ff[k]);
      end
      for (int k = 0; k < 3; k++) begin
         p1_c[k] = ext[0][k*W +: W];
         p2_c[k] = ext[1][k*W +: W];
         p3_c[k] = ext[2][k*W +: W];
         u_in[k] = p2_c[k] - p1_c[k];
         v_in[k] = p3_c[k] - p1_c[k];
         nmag[k] = n_ff[k][NW-1] ? NW'(-n_ff[k]) : NW'(n_ff[k]);
         magx[k] = MAGW'(nmag[k]);
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < 3; k++) begin
         u_ff[k]     <= u_in[k];
         v_ff[k]     <= v_in[k];
         x1_d1_ff[k] <= p1_c[k];
         x1_d2_ff[k] <= x1_d1_ff[k];
         x1_d3_ff[k] <= x1_d2_ff[k];
         px_ff[k]    <= n_ff[k] * x1_d3_ff[k];
         big_ff[k]   <= |magx[k][MAGW-1:DEGEN_MAG_BITS];
         sq_ff[k]    <= magx[k][DEGEN_MAG_BITS-1:0] * magx[k][DEGEN_MAG_BITS-1:0];
      end
      m_ff[0] <= u_ff[1] * v_ff[2];
      m_ff[1] <= u_ff[2] * v_ff[1];
      m_ff[2] <= u_ff[2] * v_ff[0];
      m_ff[3] <= u_ff[0] * v_ff[2];
      m_ff[4] <= u_ff[0] * v_ff[1];
      m_ff[5] <= u_ff[1] * v_ff[0];
      n_ff[0] <= m_ff[0] - m_ff[1];
      n_ff[1] <= m_ff[2] - m_ff[3];
      n_ff[2] <= m_ff[4] - m_ff[5];
      d_ff    <= -(px_ff[0] + px_ff[1] + px_ff[2]);
      degen_ff <= !(big_ff[0] | big_ff[1] | big_ff[2]) &&
                  ((SUMW'(sq_ff[0]) + SUMW'(sq_ff[1]) + SUMW'(sq_ff[2]))
                   < SUMW'(plane_tol_ff));
   end

   assign normal_a         = n_ff[0];
   assign normal_b         = n_ff[1];
   assign normal_c         = n_ff[2];
   assign offset_d         = d_ff;
   assign plane_degenerate = degen_ff;
   assign plane_tol        = plane_tol_ff;
   assign parallel_tol     = parallel_tol_ff;
   assign settled          = (settle_ff == 3'd0);

endmodule

// File: hw/rtl/lpi_front.sv
// ----------------------------------------------------------------------------
// lpi_front
// line intake: plane dot products, flags and the dividend per coordinate
// ----------------------------------------------------------------------------
module lpi_front import lpi_pkg::*; #(
   parameter  int W  = 16,
   localparam int RW = 4 * W + 9
) (
   input  logic                  clock,
   input  logic                  reset,
   lpi_req_if.sink               req_bus,
   input  logic signed [2*W+2:0] normal_a,
   input  logic signed [2*W+2:0] normal_b,
   input  logic signed [2*W+2:0] normal_c,
   input  logic signed [3*W+5:0] offset_d,
   input  logic                  plane_degenerate,
   input  logic [TOL_WIDTH-1:0]  plane_tol,
   input  logic [TOL_WIDTH-1:0]  parallel_tol,
   input  logic                  settled,
   input  logic                  dn_ready,
   output logic                  dn_valid,
   output logic [2:0][RW-1:0]    dn_rem,
   output logic [RW-1:0]         dn_dsh,
   output logic [2:0][W-1:0]     dn_s,
   output logic [2:0]            dn_neg,
   output flags_type             dn_flags
);

   localparam int NS   = 6;
   localparam int NW   = 2 * W + 3;
   localparam int SW   = 3 * W + 6;
   localparam int MW   = SW;
   localparam int HW   = (MW + 1) / 2;
   localparam int NNW  = W + 1 + MW;
   localparam int QB   = W + 2;
   localparam int CMPW = (MW > TOL_WIDTH) ? MW : TOL_WIDTH;

   logic [NS-1:0] v_ff;
   logic [NS-1:0] en;

   always_comb begin
      en[NS-1] = !v_ff[NS-1] || dn_ready;
      for (int i = NS - 2; i >= 0; i--) begin
         en[i] = !v_ff[i] || en[i+1];
      end
   end

   assign req_bus.ready = en[0] && settled;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (en[0]) begin
            v_ff[0] <= req_bus.valid && settled;
         end
         for (int i = 1; i < NS; i++) begin
            if (en[i]) begin
               v_ff[i] <= v_ff[i-1];
            end
         end
      end
   end

   logic signed [NW-1:0]    n_c [3];
   logic signed [W-1:0]     sreq [3];
   logic signed [W-1:0]     ereq [3];
   logic signed [W-1:0]     s0_ff [3];
   logic signed [W:0]       dv0_ff [3];
   logic signed [W-1:0]     s1_ff [3];
   logic signed [W:0]       dv1_ff [3];
   logic signed [3*W+2:0]   ns1_ff [3];
   logic signed [3*W+3:0]   nd1_ff [3];
   logic signed [W-1:0]     s2_ff [3];
   logic signed [W:0]       dv2_ff [3];
   logic signed [SW-1:0]    num2_ff;
   logic signed [SW-1:0]    den2_ff;
   logic [MW-1:0]           mn_c;
   logic [MW-1:0]           md_c;
   logic                    num_pos;
   flags_type               flags_c;
   logic [MW-1:0]           mn3_ff;
   logic [MW-1:0]           md3_ff;
   logic [W:0]              mdv3_ff [3];
   logic [2:0]              neg3_ff;
   flags_type               flags3_ff;
   logic [2:0][W-1:0]       s3_ff;
   logic [W+HW:0]           pl4_ff [3];
   logic [W+MW-HW:0]        ph4_ff [3];
   logic [MW-1:0]           md4_ff;
   logic [2:0]              neg4_ff;
   flags_type               flags4_ff;
   logic [2:0][W-1:0]       s4_ff;
   logic [NNW-1:0]          nval [3];
   logic [2:0][RW-1:0]      rem5_ff;
   logic [RW-1:0]           dsh5_ff;
   logic [2:0]              neg5_ff;
   flags_type               flags5_ff;
   logic [2:0][W-1:0]       s5_ff;

   always_comb begin
      n_c[0]  = normal_a;
      n_c[1]  = normal_b;
      n_c[2]  = normal_c;
      sreq[0] = req_bus.start_x;
      sreq[1] = req_bus.start_y;
      sreq[2] = req_bus.start_z;
      ereq[0] = req_bus.end_x;
      ereq[1] = req_bus.end_y;
      ereq[2] = req_bus.end_z;
      mn_c    = num2_ff[SW-1] ? MW'(-num2_ff) : MW'(num2_ff);
      md_c    = den2_ff[SW-1] ? MW'(-den2_ff) : MW'(den2_ff);
      num_pos = !num2_ff[SW-1] && (num2_ff != '0);
      flags_c.is_parallel      = (den2_ff == '0) || (CMPW'(md_c) < CMPW'(parallel_tol));
      flags_c.start_on_plane   = CMPW'(mn_c) < CMPW'(plane_tol);
      flags_c.plane_degenerate = plane_degenerate;
      for (int k = 0; k < 3; k++) begin
         nval[k] = (NNW'(ph4_ff[k]) << HW) + NNW'(pl4_ff[k]);
      end
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         for (int k = 0; k < 3; k++) begin
            s0_ff[k]  <= sreq[k];
            dv0_ff[k] <= ereq[k] - sreq[k];
         end
      end
      if (en[1]) begin
         for (int k = 0; k < 3; k++) begin
            s1_ff[k]  <= s0_ff[k];
            dv1_ff[k] <= dv0_ff[k];
            ns1_ff[k] <= n_c[k] * s0_ff[k];
            nd1_ff[k] <= n_c[k] * dv0_ff[k];
         end
      end
      if (en[2]) begin
         for (int k = 0; k < 3; k++) begin
            s2_ff[k]  <= s1_ff[k];
            dv2_ff[k] <= dv1_ff[k];
         end
         num2_ff <= offset_d + ns1_ff[0] + ns1_ff[1] + ns1_ff[2];
         den2_ff <= nd1_ff[0] + nd1_ff[1] + nd1_ff[2];
      end
      if (en[3]) begin
         for (int k = 0; k < 3; k++) begin
            s3_ff[k]   <= s2_ff[k];
            mdv3_ff[k] <= dv2_ff[k][W] ? (W+1)'(-dv2_ff[k]) : (W+1)'(dv2_ff[k]);
            neg3_ff[k] <= dv2_ff[k][W] ^ num_pos ^ den2_ff[SW-1];
         end
         mn3_ff    <= mn_c;
         md3_ff    <= md_c;
         flags3_ff <= flags_c;
      end
      if (en[4]) begin
         for (int k = 0; k < 3; k++) begin
            pl4_ff[k] <= mdv3_ff[k] * mn3_ff[HW-1:0];
            ph4_ff[k] <= mdv3_ff[k] * mn3_ff[MW-1:HW];
         end
         s4_ff     <= s3_ff;
         md4_ff    <= md3_ff;
         neg4_ff   <= neg3_ff;
         flags4_ff <= flags3_ff;
      end
      if (en[5]) begin
         for (int k = 0; k < 3; k++) begin
            rem5_ff[k] <= RW'(nval[k]) << 1;
         end
         dsh5_ff   <= RW'(md4_ff) << (QB + 1);
         s5_ff     <= s4_ff;
         neg5_ff   <= neg4_ff;
         flags5_ff <= flags4_ff;
      end
   end

   assign dn_valid = v_ff[NS-1];
   assign dn_rem   = rem5_ff;
   assign dn_dsh   = dsh5_ff;
   assign dn_s     = s5_ff;
   assign dn_neg   = neg5_ff;
   assign dn_flags = flags5_ff;

endmodule

// File: hw/rtl/lpi_cell.sv
// ----------------------------------------------------------------------------
// lpi_cell
// one restoring division step for three coordinate lanes
// ----------------------------------------------------------------------------
module lpi_cell import lpi_pkg::*; #(
   parameter  int W  = 16,
   localparam int RW = 4 * W + 9,
   localparam int QW = W + 4
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               up_valid,
   output logic               up_ready,
   input  logic [2:0][RW-1:0] up_rem,
   input  logic [RW-1:0]      up_dsh,
   input  logic [2:0][QW-1:0] up_q,
   input  logic [2:0][W-1:0]  up_s,
   input  logic [2:0]         up_neg,
   input  flags_type          up_flags,
   input  logic               dn_ready,
   output logic               dn_valid,
   output logic [2:0][RW-1:0] dn_rem,
   output logic [RW-1:0]      dn_dsh,
   output logic [2:0][QW-1:0] dn_q,
   output logic [2:0][W-1:0]  dn_s,
   output logic [2:0]         dn_neg,
   output flags_type          dn_flags
);

   logic               valid_ff;
   logic               en;
   logic [2:0]         ge;
   logic [2:0][RW-1:0] rem_in;
   logic [2:0][QW-1:0] q_in;
   logic [2:0][RW-1:0] rem_ff;
   logic [RW-1:0]      dsh_ff;
   logic [2:0][QW-1:0] q_ff;
   logic [2:0][W-1:0]  s_ff;
   logic [2:0]         neg_ff;
   flags_type          flags_ff;

   assign en       = !valid_ff || dn_ready;
   assign up_ready = en;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         ge[k]     = up_rem[k] >= up_dsh;
         rem_in[k] = ge[k] ? up_rem[k] - up_dsh : up_rem[k];
         q_in[k]   = {up_q[k][QW-2:0], ge[k]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff   <= rem_in;
         dsh_ff   <= up_dsh >> 1;
         q_ff     <= q_in;
         s_ff     <= up_s;
         neg_ff   <= up_neg;
         flags_ff <= up_flags;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_rem   = rem_ff;
   assign dn_dsh   = dsh_ff;
   assign dn_q     = q_ff;
   assign dn_s     = s_ff;
   assign dn_neg   = neg_ff;
   assign dn_flags = flags_ff;

endmodule

// File: hw/rtl/lpi_back.sv
// ----------------------------------------------------------------------------
// lpi_back
// rounding, sign, saturation and the result register
// ----------------------------------------------------------------------------
module lpi_back import lpi_pkg::*; #(
   parameter  int W  = 16,
   localparam int QW = W + 4
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               up_valid,
   output logic               up_ready,
   input  logic [2:0][QW-1:0] up_q,
   input  logic [2:0][W-1:0]  up_s,
   input  logic [2:0]         up_neg,
   input  flags_type          up_flags,
   lpi_rsp_if.source          rsp_bus
);

   localparam int VW = W + 4;
   localparam logic signed [VW-1:0] CMAX_V = VW'((1 << (W - 1)) - 1);
   localparam logic signed [VW-1:0] CMIN_V = ~CMAX_V;
   localparam logic [W-1:0] CMAX_W = {1'b0, {(W-1){1'b1}}};
   localparam logic [W-1:0] CMIN_W = {1'b1, {(W-1){1'b0}}};

   logic                 valid_ff;
   logic                 en;
   logic [VW-1:0]        rnd [3];
   logic signed [VW-1:0] qv [3];
   logic signed [W-1:0]  s_c [3];
   logic signed [VW-1:0] sv [3];
   logic signed [VW-1:0] v [3];
   logic [2:0]           sat_c;
   logic [2:0][W-1:0]    hit_c;
   logic [2:0][W-1:0]    hit_ff;
   logic                 sat_ff;
   flags_type            flags_ff;

   assign en       = !valid_ff || rsp_bus.ready;
   assign up_ready = en;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         rnd[k] = (VW'(up_q[k][QW-2:0]) + VW'(1)) >> 1;
         qv[k]  = signed'(rnd[k]);
         s_c[k] = signed'(up_s[k]);
         sv[k]  = VW'(s_c[k]);
         v[k]   = up_neg[k] ? sv[k] - qv[k] : sv[k] + qv[k];
         if (up_flags.is_parallel) begin
            hit_c[k] = CMAX_W;
            sat_c[k] = 1'b0;
         end else if (up_q[k][QW-1]) begin
            hit_c[k] = up_neg[k] ? CMIN_W : CMAX_W;
            sat_c[k] = 1'b1;
         end else if (v[k] > CMAX_V) begin
            hit_c[k] = CMAX_W;
            sat_c[k] = 1'b1;
         end else if (v[k] < CMIN_V) begin
            hit_c[k] = CMIN_W;
            sat_c[k] = 1'b1;
         end else begin
            hit_c[k] = v[k][W-1:0];
            sat_c[k] = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         hit_ff   <= hit_c;
         sat_ff   <= |sat_c;
         flags_ff <= up_flags;
      end
   end

   assign rsp_bus.valid            = valid_ff;
   assign rsp_bus.hit_x            = signed'(hit_ff[0]);
   assign rsp_bus.hit_y            = signed'(hit_ff[1]);
   assign rsp_bus.hit_z            = signed'(hit_ff[2]);
   assign rsp_bus.is_parallel      = flags_ff.is_parallel;
   assign rsp_bus.start_on_plane   = flags_ff.start_on_plane;
   assign rsp_bus.plane_degenerate = flags_ff.plane_degenerate;
   assign rsp_bus.hit_saturated    = sat_ff;

endmodule

// File: hw/rtl/line_plane_intersection_top.sv
// ----------------------------------------------------------------------------
// line_plane_intersection_top
// intersection of a stream of lines with a configured plane
//
// three plane points and two tolerances are written over the APB port
// (register i at byte address 8*i, 64-bit data); plane coefficients are
// derived in a register pipeline and req_bus.ready stays low until the
// settle counter has run down after reset and after every register write
// each req_bus transaction carries a line (start and end point); each
// rsp_bus transaction carries the hit point and its flags, in order
// one transaction is accepted per cycle while req_bus.ready is high;
// the path runs through the 6-stage dot product front end, the row of
// COORD_WIDTH + 4 division cells (one quotient bit each) and the result register
// a stalled receiver holds the result register; upstream stages keep
// filling empty slots, so stalls drop req_bus.ready only when the pipe is full
// reset clears all valid state and restores the default plane
// ----------------------------------------------------------------------------
module line_plane_intersection_top import lpi_pkg::*; #(
   parameter int COORD_WIDTH = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   lpi_req_if.sink               req_bus,
   lpi_rsp_if.source             rsp_bus,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [ADDR_WIDTH-1:0] paddr,
   input  logic [DATA_WIDTH-1:0] pwdata,
   output logic [DATA_WIDTH-1:0] prdata,
   output logic                  pready
);

   localparam int W  = COORD_WIDTH;
   localparam int RW = 4 * W + 9;
   localparam int QW = W + 4;
   localparam int NC = W + 4;

   logic signed [2*W+2:0] normal_a;
   logic signed [2*W+2:0] normal_b;
   logic signed [2*W+2:0] normal_c;
   logic signed [3*W+5:0] offset_d;
   logic                  plane_degenerate;
   logic [TOL_WIDTH-1:0]  plane_tol;
   logic [TOL_WIDTH-1:0]  parallel_tol;
   logic                  settled;

   logic [NC:0]                ch_valid;
   logic [NC:0]                ch_ready;
   logic [NC:0][2:0][RW-1:0]   ch_rem;
   logic [NC:0][RW-1:0]        ch_dsh;
   logic [NC:0][2:0][QW-1:0]   ch_q;
   logic [NC:0][2:0][W-1:0]    ch_s;
   logic [NC:0][2:0]           ch_neg;
   flags_type [NC:0]           ch_flags;

   lpi_plane #(.W(W)) u_plane (
      .clock            (clock),
      .reset            (reset),
      .psel             (psel),
      .penable          (penable),
      .pwrite           (pwrite),
      .paddr            (paddr),
      .pwdata           (pwdata),
      .prdata           (prdata),
      .pready           (pready),
      .normal_a         (normal_a),
      .normal_b         (normal_b),
      .normal_c         (normal_c),
      .offset_d         (offset_d),
      .plane_degenerate (plane_degenerate),
      .plane_tol        (plane_tol),
      .parallel_tol     (parallel_tol),
      .settled          (settled)
   );

   lpi_front #(.W(W)) u_front (
      .clock            (clock),
      .reset            (reset),
      .req_bus          (req_bus),
      .normal_a         (normal_a),
      .normal_b         (normal_b),
      .normal_c         (normal_c),
      .offset_d         (offset_d),
      .plane_degenerate (plane_degenerate),
      .plane_tol        (plane_tol),
      .parallel_tol     (parallel_tol),
      .settled          (settled),
      .dn_ready         (ch_ready[0]),
      .dn_valid         (ch_valid[0]),
      .dn_rem           (ch_rem[0]),
      .dn_dsh           (ch_dsh[0]),
      .dn_s             (ch_s[0]),
      .dn_neg           (ch_neg[0]),
      .dn_flags         (ch_flags[0])
   );

   assign ch_q[0] = '0;

   for (genvar i = 0; i < NC; i++) begin : g_cell
      lpi_cell #(.W(W)) u_cell (
         .clock    (clock),
         .reset    (reset),
         .up_valid (ch_valid[i]),
         .up_ready (ch_ready[i]),
         .up_rem   (ch_rem[i]),
         .up_dsh   (ch_dsh[i]),
         .up_q     (ch_q[i]),
         .up_s     (ch_s[i]),
         .up_neg   (ch_neg[i]),
         .up_flags (ch_flags[i]),
         .dn_ready (ch_ready[i+1]),
         .dn_valid (ch_valid[i+1]),
         .dn_rem   (ch_rem[i+1]),
         .dn_dsh   (ch_dsh[i+1]),
         .dn_q     (ch_q[i+1]),
         .dn_s     (ch_s[i+1]),
         .dn_neg   (ch_neg[i+1]),
         .dn_flags (ch_flags[i+1])
      );
   end

   lpi_back #(.W(W)) u_back (
      .clock    (clock),
      .reset    (reset),
      .up_valid (ch_valid[NC]),
      .up_ready (ch_ready[NC]),
      .up_q     (ch_q[NC]),
      .up_s     (ch_s[NC]),
      .up_neg   (ch_neg[NC]),
      .up_flags (ch_flags[NC]),
      .rsp_bus  (rsp_bus)
   );

endmodule

// File: tb/tb_line_plane_intersection_top.sv
// ----------------------------------------------------------------------------
// tb_line_plane_intersection_top
// self-checking bench for the line/plane intersection block
//
// a scoreboard class tracks the plane registers and predicts the hit point
// and flags of every accepted line transaction; results are matched in order
// the run steps through several plane settings (reset plane, random, extreme,
// collinear, tolerance extremes, partial and unmapped writes) under four
// mixes of sender idling and receiver stalling
// ----------------------------------------------------------------------------
module tb_line_plane_intersection_top;
   import lpi_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int W = 16;
   localparam longint CMAX = 32767;
   localparam longint CMIN = -32768;
   localparam int CYCLE_LIMIT = 400000;

   typedef struct {
      logic signed [W-1:0] sx, sy, sz, ex, ey, ez;
   } line_type;

   typedef struct {
      logic signed [W-1:0] x, y, z;
      logic                par, onp, deg, sat;
   } hit_type;

   class intersect_board_type;
      logic [47:0] pt[3];
      logic [47:0] plane_tol, par_tol;
      longint      na, nb, nc, od;
      hit_type     expected_hits[$];
      int          errors, checked;

      function new();
         pt[0] = 48'd0; pt[1] = 48'd256; pt[2] = 48'd16777216;
         plane_tol = 48'd1; par_tol = 48'd1;
         errors = 0; checked = 0;
         derive();
      endfunction

      function longint fld(logic [47:0] p, int k);
         logic signed [W-1:0] c;
         c = p[k*W +: W];
         return longint'(c);
      endfunction

      function logic [63:0] mag(longint v);
         return v < 0 ? 64'(-v) : 64'(v);
      endfunction

      function void derive();
         longint x1, y1, z1, ux, uy, uz, vx, vy, vz;
         x1 = fld(pt[0], 0); y1 = fld(pt[0], 1); z1 = fld(pt[0], 2);
         ux = fld(pt[1], 0) - x1; uy = fld(pt[1], 1) - y1; uz = fld(pt[1], 2) - z1;
         vx = fld(pt[2], 0) - x1; vy = fld(pt[2], 1) - y1; vz = fld(pt[2], 2) - z1;
         na = uy * vz - uz * vy;
         nb = uz * vx - ux * vz;
         nc = ux * vy - uy * vx;
         od = -(na * x1 + nb * y1 + nc * z1);
      endfunction

      function void write_reg(int idx, logic [63:0] val);
         case (idx)
            REG_POINT_ONE:    begin pt[0] = val[47:0]; derive(); end
            REG_POINT_TWO:    begin pt[1] = val[47:0]; derive(); end
            REG_POINT_THREE:  begin pt[2] = val[47:0]; derive(); end
            REG_PLANE_TOL:    plane_tol = val[47:0];
            REG_PARALLEL_TOL: par_tol = val[47:0];
            default: ;
         endcase
      endfunction

      function void note_line(line_type l);
         longint      s[3], dv[3], n[3], num, den, v;
         logic [127:0] prod, q, r, mden;
         logic [63:0] m[3], sum;
         bit          par, sat, neg, deg;
         hit_type     h;
         s[0] = longint'(l.sx); s[1] = longint'(l.sy); s[2] = longint'(l.sz);
         dv[0] = longint'(l.ex) - s[0];
         dv[1] = longint'(l.ey) - s[1];
         dv[2] = longint'(l.ez) - s[2];
         n[0] = na; n[1] = nb; n[2] = nc;
         num = od; den = 0; sat = 0;
         for (int k = 0; k < 3; k++) begin
            num += n[k] * s[k];
            den += n[k] * dv[k];
         end
         par = (den == 0) || (mag(den) < 64'(par_tol));
         mden = 128'(mag(den));
         for (int k = 0; k < 3; k++) begin
            if (par) begin
               v = CMAX;
            end else begin
               prod = 128'(mag(dv[k])) * 128'(mag(num));
               q = prod / mden;
               r = prod % mden;
               if ((r << 1) >= mden) q++;
               neg = ((dv[k] < 0) != (num > 0)) != (den < 0);
               if (dv[k] == 0 || num == 0) neg = 0;
               if (q > 128'd131072) v = neg ? CMIN - 1 : CMAX + 1;
               else v = neg ? s[k] - longint'(q) : s[k] + longint'(q);
               if (v > CMAX) begin v = CMAX; sat = 1; end
               if (v < CMIN) begin v = CMIN; sat = 1; end
            end
            case (k)
               0: h.x = v[W-1:0];
               1: h.y = v[W-1:0];
               default: h.z = v[W-1:0];
            endcase
         end
         m[0] = mag(na); m[1] = mag(nb); m[2] = mag(nc);
         deg = 1; sum = 0;
         for (int k = 0; k < 3; k++) begin
            if (m[k] >= 64'd16777216) deg = 0;
            else sum += m[k] * m[k];
         end
         h.par = par;
         h.onp = mag(num) < 64'(plane_tol);
         h.deg = deg && (sum < 64'(plane_tol));
         h.sat = sat;
         expected_hits.push_back(h);
      endfunction

      function void field_check(string name, longint e, longint a);
         if (e != a) begin
            errors++;
            $display("%0t mismatch %s expected %0d actual %0d", $time, name, e, a);
         end
      endfunction

      function void check_hit(hit_type a);
         hit_type e;
         if (expected_hits.size() == 0) begin
            errors++;
            $display("%0t mismatch unexpected result expected none actual x=%0d",
                     $time, a.x);
            return;
         end
         e = expected_hits.pop_front();
         checked++;
         field_check("hit_x", e.x, a.x);
         field_check("hit_y", e.y, a.y);
         field_check("hit_z", e.z, a.z);
         field_check("is_parallel", e.par, a.par);
         field_check("start_on_plane", e.onp, a.onp);
         field_check("plane_degenerate", e.deg, a.deg);
         field_check("hit_saturated", e.sat, a.sat);
      endfunction
   endclass

   logic clock, reset;
   logic psel, penable, pwrite, pready;
   logic [ADDR_WIDTH-1:0] paddr;
   logic [DATA_WIDTH-1:0] pwdata, prdata;
   int   send_idle_pct, stall_pct;
   longint cycles;
   intersect_board_type sb = new();

   lpi_req_if #(W) req_bus();
   lpi_rsp_if #(W) rsp_bus();

   line_plane_intersection_top #(.COORD_WIDTH(W)) DUT (
      .clock(clock), .reset(reset),
      .req_bus(req_bus), .rsp_bus(rsp_bus),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   initial begin
      clock = 0; reset = 1;
      psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
      req_bus.valid = 0;
      req_bus.start_x = 0; req_bus.start_y = 0; req_bus.start_z = 0;
      req_bus.end_x = 0; req_bus.end_y = 0; req_bus.end_z = 0;
      rsp_bus.ready = 0;
      send_idle_pct = 0; stall_pct = 0; cycles = 0;
   end

   always begin
      #1 clock = 1;
      #1 clock = 0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   always @(negedge clock)
      rsp_bus.ready <= ($urandom_range(0, 99) >= stall_pct);

   always @(posedge clock) begin
      hit_type a;
      line_type l;
      if (!reset) begin
         if (req_bus.valid && req_bus.ready) begin
            l.sx = req_bus.start_x; l.sy = req_bus.start_y; l.sz = req_bus.start_z;
            l.ex = req_bus.end_x; l.ey = req_bus.end_y; l.ez = req_bus.end_z;
            sb.note_line(l);
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            a.x = rsp_bus.hit_x; a.y = rsp_bus.hit_y; a.z = rsp_bus.hit_z;
            a.par = rsp_bus.is_parallel; a.onp = rsp_bus.start_on_plane;
            a.deg = rsp_bus.plane_degenerate; a.sat = rsp_bus.hit_saturated;
            sb.check_hit(a);
         end
      end
   end

   function automatic line_type mk(longint sx, sy, sz, ex, ey, ez);
      line_type l;
      l.sx = sx[W-1:0]; l.sy = sy[W-1:0]; l.sz = sz[W-1:0];
      l.ex = ex[W-1:0]; l.ey = ey[W-1:0]; l.ez = ez[W-1:0];
      return l;
   endfunction

   function automatic logic [47:0] pack(longint x, y, z);
      return {z[W-1:0], y[W-1:0], x[W-1:0]};
   endfunction

   function automatic longint small_coord();
      return longint'($urandom_range(0, 2047)) - 1024;
   endfunction

   function automatic line_type rand_line();
      line_type l;
      int kind;
      kind = $urandom_range(0, 99);
      l = mk($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
      if (kind < 40) begin
         l = mk(small_coord(), small_coord(), small_coord(),
                small_coord(), small_coord(), small_coord());
      end else if (kind < 45) begin
         l.ex = l.sx; l.ey = l.sy; l.ez = l.sz;
      end else if (kind < 60) begin
         l.sx = sb.pt[0][15:0]; l.sy = sb.pt[0][31:16]; l.sz = sb.pt[0][47:32];
         l.ex = l.sx + 16'(small_coord());
         l.ey = l.sy + 16'(small_coord());
         l.ez = l.sz + 16'(small_coord());
      end else if (kind < 75) begin
         l.ex = l.sx; l.ey = l.sy; l.ez = l.sz;
         case ($urandom_range(0, 2))
            0: l.ex = $urandom;
            1: l.ey = $urandom;
            default: l.ez = $urandom;
         endcase
      end
      return l;
   endfunction

   task automatic send_line(line_type l);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         @(negedge clock);
         req_bus.valid = 0;
      end
      @(negedge clock);
      req_bus.valid = 1;
      req_bus.start_x = l.sx; req_bus.start_y = l.sy; req_bus.start_z = l.sz;
      req_bus.end_x = l.ex; req_bus.end_y = l.ey; req_bus.end_z = l.ez;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
   endtask

   task automatic drain();
      @(negedge clock);
      req_bus.valid = 0;
      while (sb.expected_hits.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic csr_write(int idx, logic [63:0] val);
      @(negedge clock);
      psel = 1; penable = 0; pwrite = 1;
      paddr = ADDR_WIDTH'(idx * 8); pwdata = val;
      @(negedge clock);
      penable = 1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      sb.write_reg(idx, val);
      @(negedge clock);
      psel = 0; penable = 0; pwrite = 0;
   endtask

   task automatic set_plane(int setting);
      longint x, y, z, dx, dy, dz;
      x = small_coord(); y = small_coord(); z = small_coord();
      dx = small_coord(); dy = small_coord(); dz = small_coord();
      case (setting)
         1: begin
            csr_write(REG_POINT_ONE, pack(x, y, z));
            csr_write(REG_POINT_TWO, pack(small_coord(), small_coord(), small_coord()));
            csr_write(REG_POINT_THREE, pack(small_coord(), small_coord(), small_coord()));
            csr_write(REG_PLANE_TOL, 64'($urandom_range(0, 1 << 20)));
            csr_write(REG_PARALLEL_TOL, 64'($urandom_range(0, 1 << 12)));
         end
         2: begin
            csr_write(REG_POINT_ONE, {$urandom, $urandom});
            csr_write(REG_POINT_TWO, {$urandom, $urandom});
            csr_write(REG_POINT_THREE, {$urandom, $urandom});
            csr_write(REG_PLANE_TOL, 64'd0);
            csr_write(REG_PARALLEL_TOL, 64'd0);
         end
         3: begin
            csr_write(REG_POINT_ONE, pack(x, y, z));
            csr_write(REG_POINT_TWO, pack(x + dx, y + dy, z + dz));
            csr_write(REG_POINT_THREE, pack(x + 2 * dx, y + 2 * dy, z + 2 * dz));
            csr_write(REG_PLANE_TOL, 64'hFFFF_FFFF_FFFF);
         end
         4: begin
            csr_write(REG_POINT_ONE, pack(CMAX, CMAX, CMAX));
            csr_write(REG_POINT_TWO, pack(CMIN, CMIN, CMAX));
            csr_write(REG_POINT_THREE, pack(CMIN, CMAX, CMIN));
            csr_write(REG_PLANE_TOL, 64'd1);
            csr_write(REG_PARALLEL_TOL, 64'hFFFF_FFFF_FFFF);
         end
         5: begin
            csr_write(REG_POINT_ONE, {16'hFFFF, pack(x, y, z)});
            csr_write(REG_POINT_THREE, {16'hA5A5, pack(dx, dy, dz)});
            csr_write(REG_PARALLEL_TOL, {$urandom, $urandom});
            csr_write(REG_PLANE_TOL, {$urandom, $urandom});
         end
         6: begin
            csr_write(5, {$urandom, $urandom});
            csr_write(6, {$urandom, $urandom});
            csr_write(7, {$urandom, $urandom});
            csr_write(REG_POINT_TWO, pack(x, y, z));
            csr_write(REG_PARALLEL_TOL, 64'd1 << 30);
         end
         7: begin
            csr_write(REG_POINT_ONE, 64'd0);
            csr_write(REG_POINT_TWO, 64'd256);
            csr_write(REG_POINT_THREE, 64'd16777216);
            csr_write(REG_PLANE_TOL, 64'd1);
            csr_write(REG_PARALLEL_TOL, 64'd1);
         end
         default: ;
      endcase
   endtask

   initial begin
      line_type directed[$];
      int    idle_mix[4][2];
      idle_mix = '{'{0, 0}, '{85, 0}, '{0, 85}, '{12, 12}};
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 0;

      directed.push_back(mk(0, 0, 0, 0, 0, 0));
      directed.push_back(mk(CMAX, CMAX, CMAX, CMIN, CMIN, CMIN));
      directed.push_back(mk(CMIN, CMIN, CMIN, CMAX, CMAX, CMAX));
      directed.push_back(mk(CMAX, CMIN, CMAX, CMIN, CMAX, CMIN));
      directed.push_back(mk(0, 0, 256, 1, 0, -256));
      directed.push_back(mk(0, 0, 256, -1, -3, -256));
      directed.push_back(mk(0, 0, 0, 256, 256, 256));
      directed.push_back(mk(100, 200, 300, 400, 500, 300));
      directed.push_back(mk(0, 0, 2, CMAX, CMIN, 1));
      directed.push_back(mk(0, 0, 1, CMIN, CMAX, 0));
      directed.push_back(mk(CMIN, CMAX, 1, CMIN, CMAX, -1));
      directed.push_back(mk(5, 5, CMIN, 5, 5, CMAX));
      directed.push_back(mk(-1, -1, -1, 1, 1, 1));
      directed.push_back(mk(0, 0, CMAX, 0, 0, CMAX - 1));
      foreach (directed[i]) send_line(directed[i]);

      for (int seg = 0; seg < 8; seg++) begin
         send_idle_pct = idle_mix[seg % 4][0];
         stall_pct = idle_mix[seg % 4][1];
         if (seg != 0) begin
            drain();
            set_plane(seg);
         end
         repeat (68) send_line(rand_line());
      end
      drain();

      $display("checked %0d lines over 8 plane settings and 4 traffic mixes", sb.checked);
      $display("errors found: %0d", sb.errors);
      if (sb.errors == 0 && sb.expected_hits.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
